/* hdl/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared sizes for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int KEY_W    = 31;
  localparam int BC_W     = 5;
  localparam int BC_RESET = 10;
  localparam int OUT_SLOT_W = 4;
  localparam int EFF_W    = (SLOT_W + 1 > BC_W) ? SLOT_W + 1 : BC_W;

  localparam int MOD_BITS = 8;
  localparam int MOD_ITER = (KEY_W + MOD_BITS - 1) / MOD_BITS;
  localparam int MOD_PAD_W = MOD_ITER * MOD_BITS;
  localparam int MOD_ITER_W = (MOD_ITER > 1) ? $clog2(MOD_ITER) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HASH  = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

endpackage

/* hdl/linear_probe_hash_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing hash table with linear probing over a key RAM and
// occupancy flops. Search or insert, one result per operation.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   op, key
//   out      output     out_valid/out_stall hit, slot, table_full
//   cfg      input      cfg_valid/cfg_ready cfg_data (bucket count)
//
// Each operation runs the modulo unit for the home slot, then makes one key
// RAM read per probe, with 1 to min(bucket count, 16) probes (zero acts as one).
// Reset clears all occupancy bits at once; bucket count returns to 10.
// A new operation is taken while a result still waits under out_stall.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            op,
  input  logic [lpht_pkg::KEY_W-1:0]      key,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            hit,
  output logic [lpht_pkg::OUT_SLOT_W-1:0] slot,
  output logic                            table_full,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpht_pkg::BC_W-1:0]       cfg_data
);

  import lpht_pkg::*;

  state_t           state;
  logic [BC_W-1:0]  bucket_count;
  logic [EFF_W-1:0] eff;
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [SLOT_W-1:0] pos;
  logic [SLOT_W-1:0] pos_inc;
  logic [EFF_W-1:0] probes;
  logic [SLOTS-1:0] slot_valid;
  logic             r_hit;
  logic [SLOT_W-1:0] r_slot;
  logic             r_full;

  logic             in_xfer;
  logic             mod_done;
  logic [EFF_W-1:0] mod_rem;
  logic             ram_we;
  logic [SLOT_W-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  logic             empty_now;
  logic             match_now;
  logic             last_probe;
  logic             out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (bucket_count == '0) begin
      eff = EFF_W'(1);
    end else if (EFF_W'(bucket_count) > EFF_W'(SLOTS)) begin
      eff = EFF_W'(SLOTS);
    end else begin
      eff = EFF_W'(bucket_count);
    end
  end

  assign pos_inc    = (EFF_W'(pos) + 1'b1 == eff) ? '0 : pos + 1'b1;
  assign empty_now  = !slot_valid[pos];
  assign match_now  = slot_valid[pos] && (ram_rdata == key_q);
  assign last_probe = (probes == eff - 1'b1);
  assign ram_we     = (state == S_CHECK) && empty_now && op_q;
  assign ram_raddr  = (state == S_CHECK) ? pos_inc : pos;

  lpht_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (in_xfer),
    .key     (key),
    .divisor (eff),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  lpht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (key_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bucket_count <= BC_W'(BC_RESET);
      slot_valid   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bucket_count <= cfg_data;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (ram_we) begin
            slot_valid[pos] <= 1'b1;
          end
          if (empty_now || match_now || last_probe) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q  <= op;
      key_q <= key;
    end
    if (state == S_HASH && mod_done) begin
      pos    <= SLOT_W'(mod_rem);
      probes <= '0;
    end else if (state == S_CHECK) begin
      if (empty_now) begin
        r_hit  <= 1'b0;
        r_slot <= op_q ? pos : '0;
        r_full <= 1'b0;
      end else if (match_now) begin
        r_hit  <= 1'b1;
        r_slot <= pos;
        r_full <= 1'b0;
      end else if (last_probe) begin
        r_hit  <= 1'b0;
        r_slot <= '0;
        r_full <= op_q;
      end else begin
        pos    <= pos_inc;
        probes <= probes + 1'b1;
      end
    end
    if (state == S_OUT && out_free) begin
      hit        <= r_hit;
      slot       <= OUT_SLOT_W'(r_slot);
      table_full <= r_full;
    end
  end

  a_write_empty_only: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !slot_valid[pos])
    else $error("key write into occupied slot");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (probes < eff))
    else $error("probe chain ran past bucket count");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_HASH && mod_done) |-> (mod_rem < eff))
    else $error("home slot outside bucket count");

  a_hit_not_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && table_full))
    else $error("hit and table_full together");

endmodule

/* hdl/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lpht_mod.sv */
// ----------------------------------------------------------------------------
// lpht_mod
// Iterative key modulo bucket count, MOD_BITS key bits per cycle, MSB first.
// ----------------------------------------------------------------------------
module lpht_mod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  input  logic [lpht_pkg::EFF_W-1:0] divisor,
  output logic                       done,
  output logic [lpht_pkg::EFF_W-1:0] rem
);

  import lpht_pkg::*;

  logic                  busy;
  logic [MOD_ITER_W-1:0] iter;
  logic [MOD_PAD_W-1:0]  bits;
  logic [EFF_W-1:0]      rem_next;

  always_comb begin
    logic [EFF_W:0]   ext;
    logic [EFF_W-1:0] acc;
    acc = rem;
    for (int i = 0; i < MOD_BITS; i++) begin
      ext = {acc, bits[MOD_PAD_W-1-i]};
      if (ext >= {1'b0, divisor}) begin
        acc = EFF_W'(ext - {1'b0, divisor});
      end else begin
        acc = EFF_W'(ext);
      end
    end
    rem_next = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= busy && !start && (iter == MOD_ITER_W'(MOD_ITER - 1));
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == MOD_ITER_W'(MOD_ITER - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bits <= MOD_PAD_W'(key);
      rem  <= '0;
    end else if (busy) begin
      bits <= bits << MOD_BITS;
      rem  <= rem_next;
    end
  end

endmodule

/* dv/tb_linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Drives search and insert requests into the hash table and checks each
// result against an in-bench copy of the table (keys, occupancy, bucket
// count). Directed requests cover empty, duplicate, wrap, full and shrunk
// tables; random phases mix hits, duplicates, misses and sparse new inserts
// across several bucket counts, with random request gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  typedef enum logic {
    OP_SEARCH = 1'b0,
    OP_INSERT = 1'b1
  } table_op_t;

  typedef struct packed {
    table_op_t        op;
    logic [KEY_W-1:0] key;
  } table_req_t;

  typedef struct packed {
    logic                  hit;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  full;
  } table_result_t;

  localparam int RUN_LIMIT    = 400000;
  localparam int SETTLE_TICKS = 30;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  op = 1'b0;
  logic [KEY_W-1:0]      key = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  hit;
  logic [OUT_SLOT_W-1:0] slot;
  logic                  table_full;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [BC_W-1:0]       cfg_data = '0;

  // mirror of the table
  logic [BC_W-1:0]  bucket_count = BC_W'(BC_RESET);
  logic [KEY_W-1:0] slot_key [SLOTS];
  bit               slot_used [SLOTS];

  table_req_t       pending_reqs[$];
  table_result_t    expected_results[$];
  logic [KEY_W-1:0] known_keys[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  hold_sender = 1'b0;
  wire calm = (cycle_count >= 3000) && (cycle_count < 5000);

  always #5 clk = ~clk;

  linear_probe_hash_table dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .key        (key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .slot       (slot),
    .table_full (table_full),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  function automatic table_result_t probe_table(input table_op_t req_op,
                                                input logic [KEY_W-1:0] k);
    int unsigned   span;
    int unsigned   pos;
    int unsigned   at;
    int unsigned   n;
    bit            found;
    bit            empty_seen;
    table_result_t r;
    span = (bucket_count == 0) ? 1 : (bucket_count > SLOTS) ? SLOTS : bucket_count;
    pos = k % span;
    found = 1'b0;
    empty_seen = 1'b0;
    at = 0;
    n = 0;
    while (n < span && !found && !empty_seen) begin
      if (!slot_used[pos[SLOT_W-1:0]]) begin
        empty_seen = 1'b1;
        at = pos;
      end else if (slot_key[pos[SLOT_W-1:0]] == k) begin
        found = 1'b1;
        at = pos;
      end else begin
        pos = (pos + 1 == span) ? 0 : pos + 1;
      end
      n++;
    end
    r = '0;
    if (found) begin
      r.hit = 1'b1;
      r.slot = at[OUT_SLOT_W-1:0];
    end else if (req_op == OP_INSERT) begin
      if (empty_seen) begin
        slot_key[at[SLOT_W-1:0]] = k;
        slot_used[at[SLOT_W-1:0]] = 1'b1;
        r.slot = at[OUT_SLOT_W-1:0];
      end else begin
        r.full = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch @%0t: %s got %0d exp %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    table_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_results.push_back(probe_table(table_op_t'(op), key));
      end
      if (!hold_sender && pending_reqs.size() != 0 &&
          (calm || $urandom_range(0, 99) >= 20)) begin
        req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        op <= req.op;
        key <= req.key;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    table_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, slot", int'(slot), 0);
        end else begin
          want = expected_results.pop_front();
          if (hit !== want.hit) report_mismatch("hit", int'(hit), int'(want.hit));
          if (slot !== want.slot) report_mismatch("slot", int'(slot), int'(want.slot));
          if (table_full !== want.full)
            report_mismatch("table_full", int'(table_full), int'(want.full));
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 20);
    end
  end

  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_req(input table_op_t req_op, input logic [KEY_W-1:0] k);
    table_req_t req;
    req.op = req_op;
    req.key = k;
    pending_reqs.push_back(req);
    if (req_op == OP_INSERT) known_keys.push_back(k);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [BC_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    bucket_count = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    if ($urandom_range(0, 1) == 0) k = KEY_W'($urandom_range(0, 63));
    else k = KEY_W'($urandom());
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] stored_key();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  task automatic queue_random(input int count, input int new_pct);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < new_pct) push_req(OP_INSERT, fresh_key());
      else if (pick < 60 && known_keys.size() != 0) push_req(OP_SEARCH, stored_key());
      else if (pick < 75 && known_keys.size() != 0) pending_reqs.push_back({OP_INSERT, stored_key()});
      else push_req(OP_SEARCH, fresh_key());
    end
  endtask

  task automatic random_phase(input logic [BC_W-1:0] count, input int items,
                              input int new_pct, input bit pause);
    drain();
    write_bucket_count(count);
    queue_random(items, new_pct);
    if (pause) begin
      do @(negedge clk);
      while (pending_reqs.size() > items / 2);
      @(posedge clk);
      hold_sender <= 1'b1;
      do @(negedge clk);
      while (in_valid || expected_results.size() != 0);
      @(posedge clk);
      hold_sender <= 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // bucket count 10 after reset
    push_req(OP_SEARCH, 0);
    push_req(OP_INSERT, 0);
    push_req(OP_INSERT, 0);
    push_req(OP_INSERT, 10);
    push_req(OP_SEARCH, 10);
    push_req(OP_INSERT, KEY_MAX);
    push_req(OP_SEARCH, KEY_MAX);
    push_req(OP_INSERT, 9);
    push_req(OP_INSERT, 19);
    push_req(OP_SEARCH, 29);
    drain();
    // zero count acts as one: full table
    write_bucket_count(0);
    push_req(OP_INSERT, 5);
    push_req(OP_SEARCH, 0);
    push_req(OP_SEARCH, 5);
    drain();
    // saturates at the slot count
    write_bucket_count(31);
    push_req(OP_INSERT, 15);
    push_req(OP_INSERT, 31);
    push_req(OP_SEARCH, 31);
    drain();
    // shrunk table, keys beyond the count are invisible
    write_bucket_count(2);
    push_req(OP_INSERT, 4);
    push_req(OP_SEARCH, 10);
    push_req(OP_SEARCH, 19);

    random_phase(3, 66, 4, 1'b0);
    random_phase(1, 66, 4, 1'b0);
    random_phase(12, 66, 3, 1'b0);
    random_phase(0, 66, 3, 1'b0);
    random_phase(7, 66, 3, 1'b1);
    random_phase(16, 66, 3, 1'b0);
    random_phase(5, 66, 3, 1'b0);
    random_phase(31, 66, 3, 1'b0);
    random_phase(13, 66, 4, 1'b0);
    random_phase(2, 66, 4, 1'b0);
    random_phase(20, 66, 5, 1'b0);
    random_phase(16, 70, 8, 1'b0);
    drain();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/lpht_pkg.sv
hdl/lpht_ram.sv
hdl/lpht_mod.sv
hdl/linear_probe_hash_table.sv
dv/tb_linear_probe_hash_table.sv
